// File: sv/cht_pkg.sv
package cht_pkg;

    localparam int CFG_W         = 7;
    localparam int ACTION_W      = 2;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int DIV_CNT_W     = $clog2(KEY_W);

    localparam int DEF_NUM_BUCKETS   = 64;
    localparam int DEF_CHAIN_DEPTH   = 8;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    localparam logic [CFG_W-1:0] CFG_BUCKET_COUNT_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_GET    = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BASE,
        S_FILL,
        S_KEY_RD,
        S_KEY_CMP,
        S_LAST_RD,
        S_MOVE,
        S_DONE
    } state_t;

endpackage

// File: sv/cht_req_if.sv
interface cht_req_if;
    import cht_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink (input valid, input action, input key, input value, output ready);
endinterface

// File: sv/cht_rsp_if.sv
interface cht_rsp_if;
    import cht_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [VALUE_W-1:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink (input valid, input status, input read_value, output ready);
endinterface

// File: sv/chained_hash_table.sv
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   action, key, value
// rsp       out  valid/ready   status, read_value
// cfg       in   cfg_wr_en     cfg_wr_data (bucket count)
//
// One request at a time. The bucket index comes from a bit-serial remainder unit, and every
// chain entry costs one read and one compare; a remove that hits also moves the last entry
// of the bucket into the hole. After reset the bucket fill memory is swept to zero, one
// bucket per cycle; req.ready stays low during the sweep.
// A finished result waits in the output register; the next request is accepted meanwhile,
// and it holds in S_DONE only while that register is still full.
module chained_hash_table
#(
    parameter int NUM_BUCKETS   = cht_pkg::DEF_NUM_BUCKETS,
    parameter int CHAIN_DEPTH   = cht_pkg::DEF_CHAIN_DEPTH,
    parameter int PAYLOAD_WIDTH = cht_pkg::DEF_PAYLOAD_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    cht_req_if.sink                   req,
    cht_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0] cfg_wr_data
);
    import cht_pkg::*;

    localparam int TOTAL_SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int BIDX_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int FILL_W      = $clog2(CHAIN_DEPTH + 1);

    // Control registers
    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BIDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]       cfg_bucket_count_reg;

    // Datapath registers
    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [KEY_W-1:0]       dividend_reg, dividend_next;
    logic [CFG_W-1:0]       m_reg, m_next;
    logic [CFG_W-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [FILL_W-1:0]      n_reg, n_next;
    logic [FILL_W-1:0]      slot_reg, slot_next;
    logic [FILL_W-1:0]      pos_reg, pos_next;
    status_t                res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    status_t                out_status_reg, out_status_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;

    // Memories
    logic [KEY_W-1:0]          key_mem [TOTAL_SLOTS];
    logic [PAYLOAD_WIDTH-1:0]  payload_mem [TOTAL_SLOTS];
    logic [FILL_W-1:0]         fill_mem [NUM_BUCKETS];
    logic [KEY_W-1:0]          key_rd_reg;
    logic [PAYLOAD_WIDTH-1:0]  payload_rd_reg;
    logic [FILL_W-1:0]         fill_rd_reg;

    logic                      key_we;
    logic                      payload_we;
    logic [ADDR_W-1:0]         entry_rd_addr;
    logic [ADDR_W-1:0]         entry_wr_addr;
    logic [KEY_W-1:0]          key_wr_data;
    logic [PAYLOAD_WIDTH-1:0]  payload_wr_data;
    logic                      fill_we;
    logic [BIDX_W-1:0]         fill_wr_idx;
    logic [FILL_W-1:0]         fill_wr_data;
    logic [BIDX_W-1:0]         bucket;

    logic [CFG_W:0]            rem_shift;
    logic                      rem_ge;
    logic [CFG_W-1:0]          active_m;

    assign bucket        = BIDX_W'(rem_reg);
    assign entry_rd_addr = base_reg + ADDR_W'(slot_reg);
    assign entry_wr_addr = base_reg + ADDR_W'((state_reg == S_MOVE) ? pos_reg : slot_reg);
    assign key_wr_data   = (state_reg == S_MOVE) ? key_rd_reg : key_reg;
    assign payload_wr_data = (state_reg == S_MOVE) ? payload_rd_reg : PAYLOAD_WIDTH'(value_reg);

    assign rem_shift = {rem_reg, dividend_reg[KEY_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, m_reg});

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;

    // A bucket count of zero acts as one; one above NUM_BUCKETS acts as NUM_BUCKETS.
    always_comb
    begin
        active_m = cfg_bucket_count_reg;
        if (cfg_bucket_count_reg == '0)
        begin
            active_m = CFG_W'(1);
        end
        else if (32'(cfg_bucket_count_reg) > 32'(NUM_BUCKETS))
        begin
            active_m = CFG_W'(NUM_BUCKETS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_CLEAR;
            out_valid_reg        <= 1'b0;
            clr_cnt_reg          <= '0;
            cfg_bucket_count_reg <= CFG_BUCKET_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                cfg_bucket_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        dividend_reg   <= dividend_next;
        m_reg          <= m_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        base_reg       <= base_next;
        n_reg          <= n_next;
        slot_reg       <= slot_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[entry_wr_addr] <= key_wr_data;
        end
        if (payload_we)
        begin
            payload_mem[entry_wr_addr] <= payload_wr_data;
        end
        key_rd_reg     <= key_mem[entry_rd_addr];
        payload_rd_reg <= payload_mem[entry_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_wr_idx] <= fill_wr_data;
        end
        fill_rd_reg <= fill_mem[bucket];
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        clr_cnt_next    = clr_cnt_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        dividend_next   = dividend_reg;
        m_next          = m_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        key_we          = 1'b0;
        payload_we      = 1'b0;
        fill_we         = 1'b0;
        fill_wr_idx     = bucket;
        fill_wr_data    = n_reg;

        case (state_reg)
            S_CLEAR:
            begin
                fill_we      = 1'b1;
                fill_wr_idx  = clr_cnt_reg;
                fill_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + BIDX_W'(1);
                if (clr_cnt_reg == BIDX_W'(NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next     = req.action;
                    key_next        = req.key;
                    value_next      = req.value;
                    dividend_next   = req.key;
                    m_next          = active_m;
                    rem_next        = '0;
                    div_cnt_next    = '0;
                    res_status_next = ST_MISS;
                    res_value_next  = '0;
                    state_next      = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring remainder, one key bit per cycle, MSB first.
                rem_next      = rem_ge ? CFG_W'(rem_shift - {1'b0, m_reg}) : CFG_W'(rem_shift);
                dividend_next = dividend_reg << 1;
                div_cnt_next  = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(KEY_W - 1))
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                base_next  = ADDR_W'(32'(bucket) * CHAIN_DEPTH);
                state_next = S_FILL;
            end
            S_FILL:
            begin
                n_next     = fill_rd_reg;
                slot_next  = '0;
                state_next = S_KEY_RD;
            end
            S_KEY_RD:
            begin
                if (slot_reg == n_reg)
                begin
                    // Key not in the bucket.
                    state_next = S_DONE;
                    if (action_reg == ACT_PUT)
                    begin
                        if (n_reg < FILL_W'(CHAIN_DEPTH))
                        begin
                            key_we          = 1'b1;
                            payload_we      = 1'b1;
                            fill_we         = 1'b1;
                            fill_wr_data    = n_reg + FILL_W'(1);
                            res_status_next = ST_INSERTED;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
                else
                begin
                    state_next = S_KEY_CMP;
                end
            end
            S_KEY_CMP:
            begin
                if (key_rd_reg == key_reg)
                begin
                    state_next = S_DONE;
                    case (action_reg)
                        ACT_PUT:
                        begin
                            payload_we      = 1'b1;
                            res_status_next = ST_UPDATED;
                        end
                        ACT_GET:
                        begin
                            res_value_next  = VALUE_W'(payload_rd_reg);
                            res_status_next = ST_HIT;
                        end
                        ACT_REMOVE:
                        begin
                            pos_next   = slot_reg;
                            slot_next  = n_reg - FILL_W'(1);
                            state_next = S_LAST_RD;
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
                else
                begin
                    slot_next  = slot_reg + FILL_W'(1);
                    state_next = S_KEY_RD;
                end
            end
            S_LAST_RD:
            begin
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                // The last entry of the bucket fills the hole left by the removed one.
                key_we          = 1'b1;
                payload_we      = 1'b1;
                fill_we         = 1'b1;
                fill_wr_data    = n_reg - FILL_W'(1);
                res_status_next = ST_HIT;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while a request was in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KEY_RD |-> 32'(n_reg) <= 32'(CHAIN_DEPTH))
        else $error("bucket fill above chain depth");

    a_scan_in_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KEY_CMP |-> slot_reg < n_reg)
        else $error("compare beyond the bucket fill");

    a_fill_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> 32'(fill_wr_data) <= 32'(CHAIN_DEPTH))
        else $error("fill written above chain depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == S_DONE)
        else $error("result presented without a finished request");

endmodule

// File: tb/sv/chained_hash_table_tb.sv
`timescale 1ns / 100ps

module chained_hash_table_tb;
    import cht_pkg::*;

    localparam int NB              = DEF_NUM_BUCKETS;
    localparam int CHAIN           = DEF_CHAIN_DEPTH;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int FINAL_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 58;
    localparam int NUM_PHASES      = 9;
    localparam int POOL_SIZE       = 20;

    // Action code that the block does not define; it must answer not found.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  read_value;
    } lookup_result_t;

    class hash_scoreboard;
        logic [KEY_W-1:0]   slot_keys [NB*CHAIN];
        logic [VALUE_W-1:0] slot_payloads [NB*CHAIN];
        int unsigned        chain_len [NB];
        logic [CFG_W-1:0]   bucket_count;
        lookup_result_t     expected_q [$];
        int                 failures;

        function new();
            foreach (chain_len[i])
                chain_len[i] = 0;
            bucket_count = CFG_BUCKET_COUNT_RESET;
            failures = 0;
        endfunction

        function void set_bucket_count(logic [CFG_W-1:0] count);
            bucket_count = count;
        endfunction

        // Out-of-range register values are clamped to 1..NB when hashing.
        function int unsigned active_buckets();
            int unsigned m;
            m = bucket_count;
            if (m == 0)
                m = 1;
            if (m > NB)
                m = NB;
            return m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
                                   logic [VALUE_W-1:0] v);
            int unsigned    b;
            int unsigned    base;
            int unsigned    n;
            int unsigned    pos;
            lookup_result_t r;
            b = k % active_buckets();
            base = b * CHAIN;
            n = chain_len[b];
            pos = n;
            for (int i = 0; i < n; i++)
            begin
                if (pos == n && slot_keys[base + i] == k)
                    pos = i;
            end
            r.status = ST_MISS;
            r.read_value = '0;
            case (act)
                ACT_PUT:
                begin
                    if (pos < n)
                    begin
                        slot_payloads[base + pos] = v;
                        r.status = ST_UPDATED;
                    end
                    else if (n < CHAIN)
                    begin
                        slot_keys[base + n] = k;
                        slot_payloads[base + n] = v;
                        chain_len[b] = n + 1;
                        r.status = ST_INSERTED;
                    end
                    else
                        r.status = ST_FULL;
                end
                ACT_REMOVE:
                begin
                    // The last entry of the chain fills the hole.
                    if (pos < n)
                    begin
                        slot_keys[base + pos] = slot_keys[base + n - 1];
                        slot_payloads[base + pos] = slot_payloads[base + n - 1];
                        chain_len[b] = n - 1;
                        r.status = ST_HIT;
                    end
                end
                ACT_GET:
                begin
                    if (pos < n)
                    begin
                        r.read_value = slot_payloads[base + pos];
                        r.status = ST_HIT;
                    end
                end
                default:
                    ;
            endcase
            expected_q = {expected_q, r};
        endfunction

        function void check_response(status_t st, logic [VALUE_W-1:0] rd);
            lookup_result_t r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response: status %0d read_value 0x%08h", st, rd);
                failures++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", r.status, st);
                failures++;
            end
            if (rd !== r.read_value)
            begin
                $error("read_value mismatch: expected 0x%08h, actual 0x%08h",
                       r.read_value, rd);
                failures++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    cht_req_if req_if ();
    cht_rsp_if rsp_if ();

    chained_hash_table uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    hash_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;
    int             quiet_cycles;

    always #CLK_HALF clk = ~clk;

    // Response side: random back-pressure, or a long hold-off when requested.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.read_value);
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Entered just after a falling edge and left at one, so valid gets one
    // assignment per step and stays high between back-to-back transactions.
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.key    <= k;
        req_if.value  <= v;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(act, k, v);
        @(negedge clk);
    endtask

    task automatic write_bucket_count(input logic [CFG_W-1:0] count);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_bucket_count(count);
    endtask

    // Keys are drawn mostly from a small pool that lands in at most two buckets, so
    // that chains fill up, entries get updated, moved and found.
    task automatic run_random_phase(input int n_items);
        logic [KEY_W-1:0]      pool [POOL_SIZE];
        logic [KEY_W-1:0]      hi;
        logic [KEY_W-1:0]      k;
        logic [ACTION_W-1:0]   act;
        int unsigned           m;
        int unsigned           pick;
        m = sb.active_buckets();
        foreach (pool[i])
        begin
            hi = $urandom();
            pool[i] = hi - (hi % m) + $urandom_range(0, 1);
        end
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                act = ACT_PUT;
            else if (pick < 65)
                act = ACT_REMOVE;
            else if (pick < 95)
                act = ACT_GET;
            else
                act = ACT_UNUSED;
            if ($urandom_range(0, 99) < 88)
                k = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = $urandom();
            send_request(act, k, $urandom());
        end
        req_if.valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_counts [NUM_PHASES];
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_if.valid   = 1'b0;
        req_if.action  = ACT_PUT;
        req_if.key     = '0;
        req_if.value   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        sb = new();
        phase_counts = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd65, 7'd3, 7'd17, 7'd1};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part with the reset bucket count: empty table, unused
        // action, key and payload extremes, an update, then one chain filled
        // past its depth and a remove that moves the last entry.
        send_request(ACT_GET, 32'h0000_0000, 32'h0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_UNUSED, 32'h0000_0005, 32'hFFFF_FFFF);
        send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(ACT_GET, 32'h0000_0000, 32'h0);
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
        for (int i = 0; i <= CHAIN; i++)
            send_request(ACT_PUT, 5 + NB * i, 32'hA5A5_0000 + i);
        send_request(ACT_REMOVE, 5 + NB * 3, 32'h0);
        send_request(ACT_GET, 5 + NB * (CHAIN - 1), 32'h0);
        send_request(ACT_REMOVE, 5 + NB * 3, 32'h0);
        send_request(ACT_PUT, 5 + NB * CHAIN, 32'h5A5A_FFFF);
        send_request(ACT_GET, 5 + NB * CHAIN, 32'h0);
        req_if.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_bucket_count(phase_counts[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            // The sender keeps offering while responses are held back.
            if (p == 4)
                hold_left = HOLD_CYCLES;
            run_random_phase(PHASE_ITEMS);
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (FINAL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
